[design/alt_pkg.sv]
package alt_pkg;

    // Result codes on the output channel
    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_OK    = 2'd2,
        KIND_FAIL  = 2'd3
    } t_kind;

    // Parser phases, one-hot
    typedef enum logic [3:0] {
        PH_WAIT   = 4'b0001,
        PH_HEADER = 4'b0010,
        PH_DATA   = 4'b0100,
        PH_CSUM   = 4'b1000
    } t_phase;

    localparam logic [7:0]  BLOCK_START  = 8'h01;
    localparam logic [15:0] HEADER_BYTES = 16'd6;

    // Header byte positions after the leading 1
    localparam logic [2:0] HDR_SPARE    = 3'd0;
    localparam logic [2:0] HDR_COUNT_LO = 3'd1;
    localparam logic [2:0] HDR_COUNT_HI = 3'd2;
    localparam logic [2:0] HDR_ORG_LO   = 3'd3;
    localparam logic [2:0] HDR_ORG_HI   = 3'd4;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] addr;
        logic [7:0]  data;
    } t_result;

endpackage

[design/alt_front.sv]
module alt_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_tape_byte,
    input  logic              i_end_of_input,
    output logic              o_push,
    output alt_pkg::t_result  o_result
);

    alt_pkg::t_phase r_phase, n_phase;
    logic [2:0]      r_hdr_idx, n_hdr_idx;
    logic [7:0]      r_sum, n_sum;
    logic [15:0]     r_count, n_count;
    logic [15:0]     r_left, n_left;
    logic [15:0]     r_addr, n_addr;
    logic            r_done, n_done;
    logic [7:0]      sum_add;

    assign sum_add = r_sum + i_tape_byte;
    assign o_push  = i_accept;

    always_comb begin
        n_phase   = r_phase;
        n_hdr_idx = r_hdr_idx;
        n_sum     = r_sum;
        n_count   = r_count;
        n_left    = r_left;
        n_addr    = r_addr;
        n_done    = r_done;
        o_result  = '{kind: alt_pkg::KIND_NONE, addr: 16'd0, data: 8'd0};
        if (r_done) begin
            // ignore everything until reset
        end else if (i_end_of_input) begin
            n_done        = 1'b1;
            o_result.kind = alt_pkg::KIND_FAIL;
        end else begin
            unique case (r_phase)
                alt_pkg::PH_WAIT: begin
                    if (i_tape_byte == alt_pkg::BLOCK_START) begin
                        n_sum     = alt_pkg::BLOCK_START;
                        n_hdr_idx = alt_pkg::HDR_SPARE;
                        n_phase   = alt_pkg::PH_HEADER;
                    end
                end
                alt_pkg::PH_HEADER: begin
                    n_sum = sum_add;
                    unique case (r_hdr_idx)
                        alt_pkg::HDR_COUNT_LO: n_count = {r_count[15:8], i_tape_byte};
                        alt_pkg::HDR_COUNT_HI: n_count = {i_tape_byte, r_count[7:0]};
                        alt_pkg::HDR_ORG_LO:   n_addr  = {r_addr[15:8], i_tape_byte};
                        alt_pkg::HDR_ORG_HI:   n_addr  = {i_tape_byte, r_addr[7:0]};
                        default: ;
                    endcase
                    if (r_hdr_idx != alt_pkg::HDR_ORG_HI) begin
                        n_hdr_idx = r_hdr_idx + 3'd1;
                    end else begin
                        n_hdr_idx = alt_pkg::HDR_SPARE;
                        if (r_count < alt_pkg::HEADER_BYTES) begin
                            n_done        = 1'b1;
                            o_result.kind = alt_pkg::KIND_FAIL;
                        end else if (r_count == alt_pkg::HEADER_BYTES) begin
                            n_done        = 1'b1;
                            o_result.kind = alt_pkg::KIND_OK;
                        end else begin
                            n_left  = r_count - alt_pkg::HEADER_BYTES;
                            n_phase = alt_pkg::PH_DATA;
                        end
                    end
                end
                alt_pkg::PH_DATA: begin
                    n_sum         = sum_add;
                    n_addr        = r_addr + 16'd1;
                    n_left        = r_left - 16'd1;
                    o_result.kind = alt_pkg::KIND_WRITE;
                    o_result.addr = r_addr;
                    o_result.data = i_tape_byte;
                    if (r_left == 16'd1) begin
                        n_phase = alt_pkg::PH_CSUM;
                    end
                end
                alt_pkg::PH_CSUM: begin
                    n_sum   = sum_add;
                    n_phase = alt_pkg::PH_WAIT;
                    if (sum_add != 8'd0) begin
                        n_done        = 1'b1;
                        o_result.kind = alt_pkg::KIND_FAIL;
                    end
                end
                default: begin
                    n_phase = alt_pkg::PH_WAIT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= alt_pkg::PH_WAIT;
            r_hdr_idx <= 3'd0;
            r_sum     <= 8'd0;
            r_count   <= 16'd0;
            r_left    <= 16'd0;
            r_addr    <= 16'd0;
            r_done    <= 1'b0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_hdr_idx <= n_hdr_idx;
            r_sum     <= n_sum;
            r_count   <= n_count;
            r_left    <= n_left;
            r_addr    <= n_addr;
            r_done    <= n_done;
        end
    end

    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> r_done)
        else $error("load done flag cleared without reset");

    a_write_in_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_result.kind == alt_pkg::KIND_WRITE) |-> r_phase == alt_pkg::PH_DATA)
        else $error("byte write issued outside data phase");

    a_end_sets_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && (o_result.kind == alt_pkg::KIND_OK || o_result.kind == alt_pkg::KIND_FAIL))
        |=> r_done)
        else $error("load end reported but done flag not set");

endmodule

[design/alt_fifo.sv]
module alt_fifo #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  alt_pkg::t_result  i_data,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_valid,
    output alt_pkg::t_result  o_data
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);
    localparam logic [IW-1:0] IDX_ONE = IW'(1);
    localparam logic [CW-1:0] CNT_ONE = CW'(1);

    alt_pkg::t_result r_mem [DEPTH];
    logic [IW-1:0]    r_wr, n_wr;
    logic [IW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == FULL);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == LAST) ? '0 : r_wr + IDX_ONE;
        end
        if (do_pop) begin
            n_rd = (r_rd == LAST) ? '0 : r_rd + IDX_ONE;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_ONE;
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL)
        else $error("queue occupancy beyond depth");

endmodule

[design/alt_back.sv]
module alt_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  alt_pkg::t_result  i_q_data,
    output logic              o_q_pop,
    input  logic              i_stall,
    output logic              o_valid,
    output alt_pkg::t_result  o_result
);

    logic             r_valid;
    alt_pkg::t_result r_res;

    // Refill the output register when it is empty or being taken
    assign o_q_pop  = i_q_valid && (!r_valid || !i_stall);
    assign o_valid  = r_valid;
    assign o_result = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || !i_stall) begin
            r_valid <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_res <= i_q_data;
        end
    end

endmodule

[design/absolute_loader_tape_parser.sv]
// Absolute-loader paper-tape parser.
// Input channel: one tape byte per transfer (i_in_valid, o_in_stall), with
// i_end_of_input marking the end of the stream (the byte is then ignored).
// Output channel: exactly one result per input transfer, in order
// (o_out_valid, i_out_stall): nothing, a byte write (address and byte),
// load finished ok, or load failed. After ok or fail the parser ignores all
// further bytes and answers each with "nothing" until reset.
// Structure: the front parser classifies each byte and updates the block
// state in the cycle of its transfer, pushing its result into a queue of
// QUEUE_DEPTH entries; the back end drains the queue into an output register.
// Path: each result is written into the queue, then into the output register.
// Throughput: one byte per cycle, sustained, as long as the receiver keeps up;
// the parser updates its state once for each accepted byte.
// Receiver stall: the output register holds its result and the queue fills;
// o_in_stall rises only once the queue is full.
// Reset (synchronous, active low): the parser returns to waiting for a block
// start with cleared sum, count and address, and the queue and output empty.
module absolute_loader_tape_parser #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_tape_byte,
    input  logic        i_end_of_input,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_result_kind,
    output logic [15:0] o_write_address,
    output logic [7:0]  o_write_byte
);

    logic             in_accept;
    logic             front_push;
    alt_pkg::t_result front_res;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;
    alt_pkg::t_result q_data;
    alt_pkg::t_result out_res;

    // Take a byte whenever the queue has room
    assign o_in_stall = q_full;
    assign in_accept  = i_in_valid && !q_full;

    alt_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_accept),
        .i_tape_byte    (i_tape_byte),
        .i_end_of_input (i_end_of_input),
        .o_push         (front_push),
        .o_result       (front_res)
    );

    alt_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_res),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    alt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .i_stall   (i_out_stall),
        .o_valid   (o_out_valid),
        .o_result  (out_res)
    );

    assign o_result_kind   = out_res.kind;
    assign o_write_address = out_res.addr;
    assign o_write_byte    = out_res.data;

endmodule

[dv/absolute_loader_tape_parser_tb.sv]
module absolute_loader_tape_parser_tb;

    // Expected parser behavior, one result per accepted tape byte
    class loader_scoreboard;
        alt_pkg::t_result expected_results[$];
        alt_pkg::t_phase  phase;
        logic [2:0]       header_index;
        logic [7:0]       running_sum;
        logic [15:0]      block_count;
        logic [15:0]      bytes_left;
        logic [15:0]      load_address;
        logic             finished;
        int               failures;

        function new();
            phase        = alt_pkg::PH_WAIT;
            header_index = alt_pkg::HDR_SPARE;
            running_sum  = '0;
            block_count  = '0;
            bytes_left   = '0;
            load_address = '0;
            finished     = 1'b0;
            failures     = 0;
        endfunction

        function alt_pkg::t_result parse_byte(logic [7:0] b, logic eoi);
            alt_pkg::t_result r;
            r.kind = alt_pkg::KIND_NONE;
            r.addr = '0;
            r.data = '0;
            if (finished)
                return r;
            if (eoi) begin
                finished = 1'b1;
                r.kind   = alt_pkg::KIND_FAIL;
                return r;
            end
            case (phase)
                alt_pkg::PH_WAIT: begin
                    if (b == alt_pkg::BLOCK_START) begin
                        running_sum  = alt_pkg::BLOCK_START;
                        header_index = alt_pkg::HDR_SPARE;
                        phase        = alt_pkg::PH_HEADER;
                    end
                end
                alt_pkg::PH_HEADER: begin
                    running_sum = running_sum + b;
                    case (header_index)
                        alt_pkg::HDR_COUNT_LO: block_count[7:0]   = b;
                        alt_pkg::HDR_COUNT_HI: block_count[15:8]  = b;
                        alt_pkg::HDR_ORG_LO:   load_address[7:0]  = b;
                        alt_pkg::HDR_ORG_HI:   load_address[15:8] = b;
                        default: ;
                    endcase
                    if (header_index < alt_pkg::HDR_ORG_HI) begin
                        header_index = header_index + 3'd1;
                    end else begin
                        header_index = alt_pkg::HDR_SPARE;
                        if (block_count < alt_pkg::HEADER_BYTES) begin
                            finished = 1'b1;
                            r.kind   = alt_pkg::KIND_FAIL;
                        end else if (block_count == alt_pkg::HEADER_BYTES) begin
                            finished = 1'b1;
                            r.kind   = alt_pkg::KIND_OK;
                        end else begin
                            bytes_left = block_count - alt_pkg::HEADER_BYTES;
                            phase      = alt_pkg::PH_DATA;
                        end
                    end
                end
                alt_pkg::PH_DATA: begin
                    r.kind       = alt_pkg::KIND_WRITE;
                    r.addr       = load_address;
                    r.data       = b;
                    running_sum  = running_sum + b;
                    load_address = load_address + 16'd1;
                    bytes_left   = bytes_left - 16'd1;
                    if (bytes_left == 16'd0)
                        phase = alt_pkg::PH_CSUM;
                end
                default: begin
                    running_sum = running_sum + b;
                    phase       = alt_pkg::PH_WAIT;
                    if (running_sum != 8'd0) begin
                        finished = 1'b1;
                        r.kind   = alt_pkg::KIND_FAIL;
                    end
                end
            endcase
            return r;
        endfunction

        function void note_transfer(logic [7:0] b, logic eoi);
            expected_results.push_back(parse_byte(b, eoi));
        endfunction

        function void check_result(alt_pkg::t_result got);
            alt_pkg::t_result want;
            if (expected_results.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result: kind %0d addr %h byte %h",
                             got.kind, got.addr, got.data);
                return;
            end
            want = expected_results.pop_front();
            if (got.kind != want.kind || got.addr != want.addr
                    || got.data != want.data) begin
                failures++;
                if (failures <= 10)
                    $display({"mismatch: expected kind %0d addr %h byte %h,",
                              " got kind %0d addr %h byte %h"},
                             want.kind, want.addr, want.data,
                             got.kind, got.addr, got.data);
            end
        endfunction
    endclass

    typedef struct {
        logic [7:0] tape_byte;
        logic       eoi;
    } t_tape_item;

    localparam int RUN_LIMIT    = 200000;
    localparam int DRAIN_CYCLES = 16;
    localparam int RANDOM_ITEMS = 1550;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  tape_byte;
    logic        end_of_input;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  result_kind;
    logic [15:0] write_address;
    logic [7:0]  write_byte;
    logic        calm;
    int          cycle_count = 0;

    t_tape_item       tape[$];
    loader_scoreboard sb = new();

    absolute_loader_tape_parser dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_tape_byte     (tape_byte),
        .i_end_of_input  (end_of_input),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_result_kind   (result_kind),
        .o_write_address (write_address),
        .o_write_byte    (write_byte)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Append one tape item to the stream
    function void put(logic [7:0] b, logic eoi);
        t_tape_item it;
        it.tape_byte = b;
        it.eoi       = eoi;
        tape.push_back(it);
    endfunction

    // Append inter-block leader: anything but a block start
    function void put_noise(int n);
        logic [7:0] b;
        for (int i = 0; i < n; i++) begin
            do
                b = 8'($urandom_range(255));
            while (b == alt_pkg::BLOCK_START);
            put(b, 1'b0);
        end
    endfunction

    // Append a whole block; fill < 0 gives random data, csum_offset != 0
    // spoils the checksum. Return the number of items appended.
    function int put_block(logic [7:0] spare, logic [15:0] count, logic [15:0] origin,
                           int fill, logic [7:0] csum_offset);
        logic [7:0] sum;
        logic [7:0] d;
        int         ndata;
        ndata = (count > alt_pkg::HEADER_BYTES) ? int'(count - alt_pkg::HEADER_BYTES) : 0;
        put(alt_pkg::BLOCK_START, 1'b0);
        put(spare, 1'b0);
        put(count[7:0], 1'b0);
        put(count[15:8], 1'b0);
        put(origin[7:0], 1'b0);
        put(origin[15:8], 1'b0);
        sum = alt_pkg::BLOCK_START + spare + count[7:0] + count[15:8]
              + origin[7:0] + origin[15:8];
        if (count <= alt_pkg::HEADER_BYTES)
            return 6;
        for (int i = 0; i < ndata; i++) begin
            d = (fill < 0) ? 8'($urandom_range(255)) : 8'(fill);
            sum = sum + d;
            put(d, 1'b0);
        end
        put((~sum + 8'd1) + csum_offset, 1'b0);
        return 7 + ndata;
    endfunction

    // Build the whole tape: directed blocks, a long random run, then one
    // event that ends the load, then bytes that must be ignored.
    function void build_tape();
        int  len;
        int  cut;
        bit  big_done;
        big_done = 1'b0;

        // Leader extremes, then a single-byte block at the top of memory,
        // a data run that wraps the address, and a block full of start bytes
        put(8'h00, 1'b0);
        put(8'hFF, 1'b0);
        put(8'hFE, 1'b0);
        void'(put_block(8'hFF, 16'd7, 16'hFFFF, 8'hFF, 8'd0));
        void'(put_block(8'h00, 16'd8, 16'hFFFF, 8'h00, 8'd0));
        put(8'h80, 1'b0);
        void'(put_block(alt_pkg::BLOCK_START, 16'd7, 16'h0000, alt_pkg::BLOCK_START, 8'd0));

        // Well-formed blocks with random content, most with short leaders
        while (tape.size() < RANDOM_ITEMS) begin
            if ($urandom_range(99) < 60)
                put_noise($urandom_range(1, 3));
            if (!big_done && tape.size() > 700) begin
                // Count with a nonzero high byte
                void'(put_block(8'($urandom_range(255)),
                                16'h0106 + 16'($urandom_range(1, 20)),
                                16'($urandom_range(16'hFFFF)), -1, 8'd0));
                big_done = 1'b1;
            end else begin
                void'(put_block(8'($urandom_range(255)), 16'($urandom_range(7, 40)),
                                16'($urandom_range(16'hFFFF)), -1, 8'd0));
            end
        end

        // End the load in one of its possible ways
        case ($urandom_range(3))
            0: begin
                // End block; its start address goes unused
                put_noise($urandom_range(0, 2));
                void'(put_block(8'($urandom_range(255)), alt_pkg::HEADER_BYTES,
                                16'($urandom_range(16'hFFFF)), -1, 8'd0));
            end
            1: begin
                // Short count
                void'(put_block(8'($urandom_range(255)), 16'($urandom_range(0, 5)),
                                16'($urandom_range(16'hFFFF)), -1, 8'd0));
            end
            2: begin
                // Bad checksum
                void'(put_block(8'($urandom_range(255)), 16'($urandom_range(7, 20)),
                                16'($urandom_range(16'hFFFF)), -1,
                                8'($urandom_range(1, 255))));
            end
            default: begin
                // Early end, either between blocks or cut inside one
                if ($urandom_range(3) != 0) begin
                    len = put_block(8'($urandom_range(255)), 16'($urandom_range(7, 20)),
                                    16'($urandom_range(16'hFFFF)), -1, 8'd0);
                    cut = $urandom_range(1, len - 1);
                    repeat (cut) void'(tape.pop_back());
                end else begin
                    put_noise($urandom_range(0, 2));
                end
                put(8'($urandom_range(255)), 1'b1);
            end
        endcase

        // Everything after the end is ignored, end markers included
        for (int i = 0; i < 16; i++)
            put(8'($urandom_range(255)), 1'($urandom_range(1)));
    endfunction

    // Receiver side: random stall outside the calm stretch
    always @(posedge clk) begin
        if (!rst_n || calm)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < 24);
    end

    // Note every accepted tape byte
    always @(posedge clk) begin
        if (rst_n && in_valid && !in_stall)
            sb.note_transfer(tape_byte, end_of_input);
    end

    // Check every accepted result against the oldest expectation
    always @(posedge clk) begin
        alt_pkg::t_result got;
        if (rst_n && out_valid && !out_stall) begin
            got.kind = alt_pkg::t_kind'(result_kind);
            got.addr = write_address;
            got.data = write_byte;
            sb.check_result(got);
        end
    end

    initial begin : watchdog
        wait (cycle_count >= RUN_LIMIT);
        $display("absolute_loader_tape_parser_tb: FAIL");
        $finish;
    end

    initial begin : main
        int idx;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        tape_byte    <= 8'h00;
        end_of_input <= 1'b0;
        calm         <= 1'b0;
        build_tape();

        // Hold reset, then release it at an edge
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Feed the tape; each loop pass makes one assignment per step, so a
        // back-to-back transfer keeps valid high without a glitch
        idx = 0;
        while (idx < tape.size()) begin
            calm <= (idx >= 400 && idx < 800);
            if (!(idx >= 400 && idx < 800) && $urandom_range(99) < 24) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end else begin
                in_valid     <= 1'b1;
                tape_byte    <= tape[idx].tape_byte;
                end_of_input <= tape[idx].eoi;
                // Hold the payload until the transfer happens
                do
                    @(posedge clk);
                while (in_stall);
                idx++;
            end
        end
        in_valid <= 1'b0;
        calm     <= 1'b0;

        // Drain outstanding results, then keep watching for stray results
        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.failures == 0 && sb.expected_results.size() == 0)
            $display("absolute_loader_tape_parser_tb: PASS");
        else
            $display("absolute_loader_tape_parser_tb: FAIL");
        $finish;
    end

endmodule

[absolute_loader_tape_parser.f]
design/alt_pkg.sv
design/alt_front.sv
design/alt_fifo.sv
design/alt_back.sv
design/absolute_loader_tape_parser.sv
dv/absolute_loader_tape_parser_tb.sv
